// File: hdl/r4ntt_pkg.sv
// shared constants, types and command struct of the radix-4 ntt unit
// used by the controller, datapath and top level
`default_nettype none
package r4ntt_pkg;
   localparam int VAL_BITS = 51;
   localparam int POINTS = 64;
   localparam int PBITS = 6;
   localparam int TW_SLOTS = 60;
   localparam int TWBITS = 6;
   localparam int MRED_STEPS = 7;

   localparam logic OP_TWIDDLE = 1'b0;
   localparam logic OP_COEF    = 1'b1;

   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_ROOT    = 1'b1;

   // controller commands to the datapath
   typedef enum logic [2:0] {
      DP_NOP, DP_RED_START, DP_BFLY_START, DP_EMIT_READ
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [PBITS-1:0] p0;
      logic [PBITS-1:0] p1;
      logic [PBITS-1:0] p2;
      logic [PBITS-1:0] p3;
      logic             use_tw;
      logic [TWBITS-1:0] w1;
      logic [TWBITS-1:0] w2;
      logic [TWBITS-1:0] w3;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
   } dp_sts_type;
endpackage
`default_nettype wire

// File: hdl/r4ntt_datapath.sv
// datapath: coefficient and twiddle memories, modular reduce, add/sub and
// bit-serial modular multiplier shared by all butterflies; uses r4ntt_pkg
`default_nettype none
module r4ntt_datapath
   import r4ntt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_sts_type               sts,
   input  wire logic [VAL_BITS-1:0] modulus,
   input  wire logic [VAL_BITS-1:0] fourth_root,
   input  wire logic                coef_we,
   input  wire logic [PBITS-1:0]    coef_addr,
   input  wire logic                tw_we,
   input  wire logic [TWBITS-1:0]   tw_addr,
   input  wire logic [VAL_BITS-1:0] wr_data,
   output logic      [VAL_BITS-1:0] rd_data
);
   // memories
   logic [VAL_BITS-1:0] coef_mem [POINTS];
   logic [VAL_BITS-1:0] tw_mem   [TW_SLOTS];

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RED_RD = 4'd1;
   localparam logic [3:0] S_RED    = 4'd2;
   localparam logic [3:0] S_LD     = 4'd3;
   localparam logic [3:0] S_ADD1   = 4'd4;
   localparam logic [3:0] S_MUL_Z  = 4'd5;
   localparam logic [3:0] S_ADD2   = 4'd6;
   localparam logic [3:0] S_MUL_W  = 4'd7;
   localparam logic [3:0] S_WB     = 4'd8;
   localparam logic [3:0] S_RED_Z  = 4'd9;

   logic [3:0] st_ff, st_in;
   logic [VAL_BITS-1:0] m_ff;
   logic [7:0] idx_ff;
   logic [2:0] ph_ff;
   dp_cmd_type c_ff;
   logic [VAL_BITS-1:0] z_ff;
   logic [VAL_BITS-1:0] c_r [4];
   logic [VAL_BITS-1:0] w_r [3];

   // reducer: r = x mod m by restoring division over 51 bit-steps
   logic [VAL_BITS-1:0] rx_ff, rr_ff;
   logic [5:0] rcnt_ff;
   logic [VAL_BITS:0] rsh;
   assign rsh = {rr_ff, rx_ff[VAL_BITS-1]};

   // multiplier: shift-add modulo m, one bit a cycle
   logic [VAL_BITS-1:0] ma_ff, mb_ff, macc_ff;
   logic [VAL_BITS:0] dbl, dblr, addv;
   logic [VAL_BITS-1:0] dbl_m;
   always_comb begin
      dbl = {macc_ff, 1'b0};
      dblr = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      dbl_m = dblr[VAL_BITS-1:0];
      addv = {1'b0, dbl_m} + {1'b0, ma_ff};
      if (addv >= {1'b0, m_ff}) addv = addv - {1'b0, m_ff};
   end

   function automatic logic [VAL_BITS-1:0] addm(input logic [VAL_BITS-1:0] x,
      input logic [VAL_BITS-1:0] y, input logic [VAL_BITS-1:0] m);
      logic [VAL_BITS:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[VAL_BITS-1:0];
   endfunction
   function automatic logic [VAL_BITS-1:0] subm(input logic [VAL_BITS-1:0] x,
      input logic [VAL_BITS-1:0] y, input logic [VAL_BITS-1:0] m);
      return (x >= y) ? x - y : x + (m - y);
   endfunction

   logic [PBITS-1:0] rd_pos;
   logic [TWBITS-1:0] rd_tw;
   always_comb begin
      unique case (ph_ff[1:0])
         2'd0: rd_pos = c_ff.p0;
         2'd1: rd_pos = c_ff.p1;
         2'd2: rd_pos = c_ff.p2;
         default: rd_pos = c_ff.p3;
      endcase
      unique case (ph_ff[1:0])
         2'd0: rd_tw = c_ff.w1;
         2'd1: rd_tw = c_ff.w2;
         default: rd_tw = c_ff.w3;
      endcase
   end

   logic [VAL_BITS-1:0] coef_q, tw_q;
   logic [PBITS-1:0] coef_ra;
   logic [TWBITS-1:0] tw_ra;
   logic coef_mw;
   logic [PBITS-1:0] coef_wa;
   logic [VAL_BITS-1:0] coef_wd;

   // read addresses
   always_comb begin
      coef_ra = rd_pos;
      tw_ra = rd_tw;
      if (st_ff == S_RED_RD || st_ff == S_RED) begin
         coef_ra = idx_ff[PBITS-1:0];
         tw_ra = idx_ff[TWBITS-1:0] - TWBITS'(POINTS);
      end
      if (cmd.op == DP_EMIT_READ) coef_ra = cmd.p0;
   end

   always_ff @(posedge clock) begin
      coef_q <= coef_mem[coef_ra];
      tw_q <= tw_mem[tw_ra];
      if (coef_mw) coef_mem[coef_wa] <= coef_wd;
      if (tw_we && tw_addr < TWBITS'(TW_SLOTS)) tw_mem[tw_addr] <= wr_data;
   end
   assign rd_data = coef_q;

   logic [VAL_BITS-1:0] d0, d1, d2;
   logic [VAL_BITS-1:0] sel_w;
   logic twred_we;

   // memory write port mux
   always_comb begin
      coef_mw = coef_we;
      coef_wa = coef_addr;
      coef_wd = wr_data;
      twred_we = 1'b0;
      if (st_ff == S_RED && rcnt_ff == 6'd0 && idx_ff < 8'(POINTS)) begin
         coef_mw = 1'b1;
         coef_wa = idx_ff[PBITS-1:0];
         coef_wd = rr_ff;
      end else if (st_ff == S_RED && rcnt_ff == 6'd0) begin
         twred_we = 1'b1;
      end else if (st_ff == S_WB) begin
         coef_mw = 1'b1;
         coef_wa = rd_pos;
         coef_wd = c_r[ph_ff[1:0]];
      end
   end

   always_comb begin
      d0 = addm(c_r[0], c_r[2], m_ff);
      d1 = subm(c_r[0], c_r[2], m_ff);
      d2 = addm(c_r[1], c_r[3], m_ff);
      unique case (ph_ff[1:0])
         2'd0: sel_w = w_r[0];
         2'd1: sel_w = w_r[1];
         default: sel_w = w_r[2];
      endcase
   end

   // reduced twiddles; w1..w3 are fetched in load phases 0 to 2
   logic [VAL_BITS-1:0] twr_mem [TW_SLOTS];
   always_ff @(posedge clock) begin
      if (twred_we) twr_mem[idx_ff[TWBITS-1:0] - TWBITS'(POINTS)] <= rr_ff;
      if (st_ff == S_LD && ph_ff < 3'd3) w_r[ph_ff[1:0]] <= twr_mem[rd_tw];
   end

   // sequencing
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (cmd.op == DP_RED_START) st_in = S_RED_Z;
            else if (cmd.op == DP_BFLY_START) st_in = S_LD;
         end
         S_RED_Z: st_in = (rcnt_ff == 6'd0) ? S_RED_RD : S_RED_Z;
         S_RED_RD: st_in = S_RED;
         S_RED: st_in = (rcnt_ff == 6'd0)
                        ? ((idx_ff == 8'(POINTS + TW_SLOTS - 1)) ? S_IDLE : S_RED_RD)
                        : S_RED;
         S_LD: st_in = (ph_ff == 3'd4) ? S_ADD1 : S_LD;
         S_ADD1: st_in = S_MUL_Z;
         S_MUL_Z: st_in = (rcnt_ff == 6'd0) ? S_ADD2 : S_MUL_Z;
         S_ADD2: st_in = c_ff.use_tw ? S_MUL_W : S_WB;
         S_MUL_W: st_in = (rcnt_ff == 6'd0 && ph_ff == 3'd2) ? S_WB : S_MUL_W;
         S_WB: st_in = (ph_ff == 3'd3) ? S_IDLE : S_WB;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
   end
   assign sts.busy = (st_ff != S_IDLE);

   always_ff @(posedge clock) begin
      unique case (st_ff)
         S_IDLE: begin
            c_ff <= cmd;
            ph_ff <= 3'd0;
            if (cmd.op == DP_RED_START) begin
               m_ff <= (modulus < VAL_BITS'(2)) ? VAL_BITS'(1) : modulus;
               rx_ff <= fourth_root;
               rr_ff <= '0;
               rcnt_ff <= 6'(VAL_BITS);
               idx_ff <= '0;
            end
         end
         S_RED_Z: begin
            if (rcnt_ff != 6'd0) begin
               rx_ff <= {rx_ff[VAL_BITS-2:0], 1'b0};
               rr_ff <= (rsh >= {1'b0, m_ff}) ? VAL_BITS'(rsh - {1'b0, m_ff})
                                              : rsh[VAL_BITS-1:0];
               rcnt_ff <= rcnt_ff - 6'd1;
            end else z_ff <= rr_ff;
         end
         S_RED_RD: begin
            rcnt_ff <= 6'(VAL_BITS + 1);
         end
         S_RED: begin
            if (rcnt_ff == 6'(VAL_BITS + 1)) begin
               rx_ff <= (idx_ff < 8'(POINTS)) ? coef_q : tw_q;
               rr_ff <= '0;
               rcnt_ff <= rcnt_ff - 6'd1;
            end else if (rcnt_ff != 6'd0) begin
               rx_ff <= {rx_ff[VAL_BITS-2:0], 1'b0};
               rr_ff <= (rsh >= {1'b0, m_ff}) ? VAL_BITS'(rsh - {1'b0, m_ff})
                                              : rsh[VAL_BITS-1:0];
               rcnt_ff <= rcnt_ff - 6'd1;
            end else idx_ff <= idx_ff + 8'd1;
         end
         S_LD: begin
            if (ph_ff != 3'd0) c_r[ph_ff[1:0] - 2'd1] <= coef_q;
            ph_ff <= ph_ff + 3'd1;
         end
         S_ADD1: begin
            ma_ff <= subm(c_r[1], c_r[3], m_ff);
            mb_ff <= z_ff;
            macc_ff <= '0;
            rcnt_ff <= 6'(VAL_BITS);
            c_r[0] <= d0;
            c_r[1] <= d1;
            c_r[2] <= d2;
         end
         S_MUL_Z: begin
            if (rcnt_ff != 6'd0) begin
               macc_ff <= mb_ff[VAL_BITS-1] ? addv[VAL_BITS-1:0] : dbl_m;
               mb_ff <= {mb_ff[VAL_BITS-2:0], 1'b0};
               rcnt_ff <= rcnt_ff - 6'd1;
            end
         end
         S_ADD2: begin
            // d0=c0 d1=c1 d2=c2 d3=macc
            c_r[0] <= addm(c_r[0], c_r[2], m_ff);
            c_r[1] <= addm(c_r[1], macc_ff, m_ff);
            c_r[2] <= subm(c_r[0], c_r[2], m_ff);
            c_r[3] <= subm(c_r[1], macc_ff, m_ff);
            ph_ff <= 3'd0;
            rcnt_ff <= 6'(VAL_BITS + 1);
         end
         S_MUL_W: begin
            if (rcnt_ff == 6'(VAL_BITS + 1)) begin
               ma_ff <= c_r[ph_ff[1:0] + 2'd1];
               mb_ff <= sel_w;
               macc_ff <= '0;
               rcnt_ff <= rcnt_ff - 6'd1;
            end else if (rcnt_ff != 6'd0) begin
               macc_ff <= mb_ff[VAL_BITS-1] ? addv[VAL_BITS-1:0] : dbl_m;
               mb_ff <= {mb_ff[VAL_BITS-2:0], 1'b0};
               rcnt_ff <= rcnt_ff - 6'd1;
            end else begin
               c_r[ph_ff[1:0] + 2'd1] <= macc_ff;
               ph_ff <= (ph_ff == 3'd2) ? 3'd0 : ph_ff + 3'd1;
               rcnt_ff <= 6'(VAL_BITS + 1);
            end
         end
         S_WB: begin
            ph_ff <= ph_ff + 3'd1;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// File: hdl/r4ntt_ctrl.sv
// controller: load counting, butterfly schedule of the three stages and
// result emission; uses r4ntt_pkg, drives r4ntt_datapath by command struct
`default_nettype none
module r4ntt_ctrl
   import r4ntt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic                in_op,
   output logic                     coef_we,
   output logic [PBITS-1:0]         coef_addr,
   output logic                     tw_we,
   output dp_cmd_type               cmd,
   input  wire dp_sts_type          sts,
   input  wire logic [VAL_BITS-1:0] rd_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [VAL_BITS-1:0]      out_residue,
   output logic [PBITS-1:0]         out_position,
   output logic                     out_last
);
   localparam logic [2:0] C_LOAD  = 3'd0;
   localparam logic [2:0] C_RED   = 3'd1;
   localparam logic [2:0] C_BFLY  = 3'd2;
   localparam logic [2:0] C_WAIT  = 3'd3;
   localparam logic [2:0] C_EMRD  = 3'd4;
   localparam logic [2:0] C_EMLAT = 3'd5;
   localparam logic [2:0] C_EMIT  = 3'd6;
   localparam logic [2:0] C_RWAIT = 3'd7;

   logic [2:0] st_ff;
   logic [PBITS:0] cnt_ff;
   logic [1:0] stage_ff;
   logic [3:0] bf_ff;
   logic launched_ff;

   assign in_ready = (st_ff == C_LOAD);
   assign coef_we = in_valid && in_ready && (in_op == OP_COEF);
   assign tw_we = in_valid && in_ready && (in_op == OP_TWIDDLE);
   assign coef_addr = cnt_ff[PBITS-1:0];

   // butterfly addresses per stage
   logic [1:0] ln;
   logic [1:0] blk;
   always_comb begin
      ln = bf_ff[1:0];
      blk = bf_ff[3:2];
      cmd = '0;
      cmd.op = DP_NOP;
      unique case (stage_ff)
         2'd0: begin
            cmd.p0 = {2'd0, bf_ff};
            cmd.p1 = {2'd1, bf_ff};
            cmd.p2 = {2'd2, bf_ff};
            cmd.p3 = {2'd3, bf_ff};
            cmd.use_tw = 1'b1;
            cmd.w1 = {2'd0, bf_ff};
            cmd.w2 = {2'd1, bf_ff};
            cmd.w3 = {2'd2, bf_ff};
         end
         2'd1: begin
            cmd.p0 = {blk, 2'd0, ln};
            cmd.p1 = {blk, 2'd1, ln};
            cmd.p2 = {blk, 2'd2, ln};
            cmd.p3 = {blk, 2'd3, ln};
            cmd.use_tw = 1'b1;
            cmd.w1 = 6'd48 + {4'd0, ln};
            cmd.w2 = 6'd52 + {4'd0, ln};
            cmd.w3 = 6'd56 + {4'd0, ln};
         end
         default: begin
            cmd.p0 = {bf_ff, 2'd0};
            cmd.p1 = {bf_ff, 2'd1};
            cmd.p2 = {bf_ff, 2'd2};
            cmd.p3 = {bf_ff, 2'd3};
            cmd.use_tw = 1'b0;
         end
      endcase
      if (st_ff == C_RED && !launched_ff) cmd.op = DP_RED_START;
      if (st_ff == C_BFLY) cmd.op = DP_BFLY_START;
      if (st_ff == C_EMRD) begin
         cmd.op = DP_EMIT_READ;
         cmd.p0 = cnt_ff[PBITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= C_LOAD;
         cnt_ff <= '0;
         stage_ff <= '0;
         bf_ff <= '0;
         launched_ff <= 1'b0;
         out_valid <= 1'b0;
      end else begin
         unique case (st_ff)
            C_LOAD: if (coef_we) begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 7'(POINTS - 1)) begin
                  st_ff <= C_RED;
                  launched_ff <= 1'b0;
               end
            end
            C_RED: begin
               launched_ff <= 1'b1;
               if (launched_ff && !sts.busy) begin
                  st_ff <= C_BFLY;
                  stage_ff <= '0;
                  bf_ff <= '0;
               end
            end
            C_BFLY: st_ff <= C_WAIT;
            C_WAIT: if (!sts.busy) begin
               bf_ff <= bf_ff + 4'd1;
               if (bf_ff == 4'd15) begin
                  if (stage_ff == 2'd2) begin
                     st_ff <= C_EMRD;
                     cnt_ff <= '0;
                  end else begin
                     stage_ff <= stage_ff + 2'd1;
                     st_ff <= C_BFLY;
                  end
               end else st_ff <= C_BFLY;
            end
            C_EMRD: st_ff <= C_EMLAT;
            C_EMLAT: begin
               out_residue <= rd_data;
               out_position <= cnt_ff[PBITS-1:0];
               out_last <= (cnt_ff == 7'(POINTS - 1));
               out_valid <= 1'b1;
               st_ff <= C_EMIT;
            end
            C_EMIT: if (out_ready) begin
               out_valid <= 1'b0;
               cnt_ff <= cnt_ff + 1'b1;
               st_ff <= (cnt_ff == 7'(POINTS - 1)) ? C_RWAIT : C_EMRD;
            end
            default: begin
               cnt_ff <= '0;
               st_ff <= C_LOAD;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// File: hdl/radix4_dif_ntt_64_unit.sv
// top level of the 64-point radix-4 dif ntt unit
// instantiates r4ntt_ctrl and r4ntt_datapath, uses r4ntt_pkg
//
// usage:
//  - csr channel writes modulus (index 0) and fourth root (index 1) while idle
//  - req channel takes words: tuser selects twiddle write (0) or coefficient (1)
//  - twiddle words are taken back to back while loading and give no result
//  - coefficients are taken back to back too; the 64th starts the transform
//  - the transform first reduces the root, then 64 coefficients
//    and 60 twiddles modulo p with a bit-serial reducer
//  - then 48 butterflies in one shared unit with a bit-serial modular
//    multiplier; the last stage skips the twiddle products
//  - 64 result words then leave in position order, each read after the
//    previous one is taken, tlast on position 63
//  - req_tready is low from the 64th coefficient until the last result leaves
//  - a stalled receiver simply holds the current result word
//  - reset returns to loading with load count zero; memories keep contents
`default_nettype none
module radix4_dif_ntt_64_unit
   import r4ntt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // slot[5:0], value[56:6], zero fill
   input  wire logic        req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // residue[50:0], position[56:51], zero fill
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [50:0] csr_data
);
   logic [VAL_BITS-1:0] modulus_ff, root_ff;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= VAL_BITS'(3);
         root_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_data;
            default:     root_ff <= csr_data;
         endcase
      end
   end

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic coef_we, tw_we;
   logic [PBITS-1:0] coef_addr;
   logic [VAL_BITS-1:0] rd_data, res;
   logic [PBITS-1:0] pos;

   r4ntt_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_op(req_tuser),
      .coef_we, .coef_addr, .tw_we, .cmd, .sts, .rd_data,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_residue(res), .out_position(pos), .out_last(rsp_tlast)
   );

   r4ntt_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .modulus(modulus_ff), .fourth_root(root_ff),
      .coef_we, .coef_addr, .tw_we, .tw_addr(req_tdata[5:0]),
      .wr_data(req_tdata[56:6]), .rd_data
   );

   assign rsp_tdata = {7'd0, pos, res};
endmodule
`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench of the 64-point radix-4 dif ntt unit
// depends on r4ntt_pkg and radix4_dif_ntt_64_unit only
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import r4ntt_pkg::*;

   typedef struct packed {
      logic [50:0] residue;
      logic [5:0]  position;
      logic        last;
   } ntt_out_type;

   localparam longint unsigned P_LARGE = 64'd2251799813685119;
   localparam int WATCHDOG_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [50:0] csr_data = '0;

   radix4_dif_ntt_64_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   longint unsigned cfg_modulus = 3, cfg_root = 0;
   longint unsigned coef_store[64];
   longint unsigned tw_store[60];
   int              coef_count = 0;
   ntt_out_type     expected_q[$];
   int              errors = 0;
   int              send_idle_pct = 0, recv_stall_pct = 0;
   int              idle_cycles = 0;

   function automatic longint unsigned mod_add(longint unsigned x, y, m);
      longint unsigned s = x + y;
      return (s >= m) ? s - m : s;
   endfunction

   function automatic longint unsigned mod_sub(longint unsigned x, y, m);
      return (x >= y) ? x - y : x + (m - y);
   endfunction

   function automatic longint unsigned mod_mul(longint unsigned a, b, m);
      longint unsigned r = 0;
      for (int k = 50; k >= 0; k--) begin
         r = mod_add(r, r, m);
         if (b[k]) r = mod_add(r, a, m);
      end
      return r;
   endfunction

   // run the three dif stages and queue the 64 expected words
   task automatic predict_transform();
      longint unsigned v[64];
      longint unsigned tw[60];
      longint unsigned m, z, c0, c1, c2, c3, d0, d1, d2, d3;
      int p[4], w[3];
      bit use_tw;
      ntt_out_type o;
      m = (cfg_modulus < 2) ? 1 : cfg_modulus;
      z = cfg_root % m;
      foreach (v[i]) v[i] = coef_store[i] % m;
      foreach (tw[i]) tw[i] = tw_store[i] % m;
      for (int b = 0; b < 48; b++) begin
         if (b < 16) begin
            p = '{b, b + 16, b + 32, b + 48};
            w = '{b, 16 + b, 32 + b};
            use_tw = 1;
         end else if (b < 32) begin
            p[0] = ((b - 16) / 4) * 16 + (b % 4);
            p = '{p[0], p[0] + 4, p[0] + 8, p[0] + 12};
            w = '{48 + b % 4, 52 + b % 4, 56 + b % 4};
            use_tw = 1;
         end else begin
            p = '{(b - 32) * 4, (b - 32) * 4 + 1, (b - 32) * 4 + 2, (b - 32) * 4 + 3};
            use_tw = 0;
         end
         c0 = v[p[0]]; c1 = v[p[1]]; c2 = v[p[2]]; c3 = v[p[3]];
         d0 = mod_add(c0, c2, m);
         d1 = mod_sub(c0, c2, m);
         d2 = mod_add(c1, c3, m);
         d3 = mod_mul(mod_sub(c1, c3, m), z, m);
         v[p[0]] = mod_add(d0, d2, m);
         v[p[1]] = mod_add(d1, d3, m);
         v[p[2]] = mod_sub(d0, d2, m);
         v[p[3]] = mod_sub(d1, d3, m);
         if (use_tw) begin
            v[p[1]] = mod_mul(v[p[1]], tw[w[0]], m);
            v[p[2]] = mod_mul(v[p[2]], tw[w[1]], m);
            v[p[3]] = mod_mul(v[p[3]], tw[w[2]], m);
         end
      end
      for (int i = 0; i < 64; i++) begin
         o.residue = v[i][50:0];
         o.position = i[5:0];
         o.last = (i == 63);
         expected_q.push_back(o);
      end
   endtask

   // send one word on the request channel and update the predictor;
   // valid stays high after the word so the next one can follow directly
   task automatic send_word(input logic op, input logic [5:0] slot,
                            input logic [50:0] value);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, value, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_TWIDDLE) begin
         if (slot < 60) tw_store[slot] = value;
      end else begin
         coef_store[coef_count] = value;
         coef_count++;
         if (coef_count == 64) begin
            coef_count = 0;
            predict_transform();
         end
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input longint unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[50:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MODULUS) cfg_modulus = value[50:0];
      else cfg_root = value[50:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [50:0] rand_value();
      return 51'({$urandom(), $urandom()} >> 13);
   endfunction

   task automatic load_all_twiddles(input bit random_values);
      for (int s = 0; s < 60; s++)
         send_word(OP_TWIDDLE, s[5:0], random_values ? rand_value() : 51'(s + 2));
   endtask

   task automatic send_block(input int kind);
      logic [50:0] v;
      for (int i = 0; i < 64; i++) begin
         case (kind)
            0: v = '1;
            1: v = '0;
            default: v = rand_value();
         endcase
         // an occasional ignored twiddle write between coefficients
         if (kind == 2 && $urandom_range(15, 0) == 0)
            send_word(OP_TWIDDLE, 6'(60 + $urandom_range(3, 0)), rand_value());
         send_word(OP_COEF, 6'($urandom_range(63, 0)), v);
      end
   endtask

   // directed: reset modulus, extremes, out-of-range slots
   task automatic test_directed();
      load_all_twiddles(1);
      send_word(OP_TWIDDLE, 6'd63, '1);
      send_word(OP_TWIDDLE, 6'd60, '1);
      send_block(0);
      wait_drained();
      write_csr(CSR_MODULUS, 0);
      write_csr(CSR_ROOT, 64'h7_FFFF_FFFF_FFFF);
      send_block(1);
      wait_drained();
   endtask

   // random content at several settings and idling phases; the raw twiddles
   // stored earlier are reduced with the modulus in force at start
   task automatic test_random(input longint unsigned m, root, input int idle,
                              input int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      write_csr(CSR_MODULUS, m);
      write_csr(CSR_ROOT, root);
      send_block(2);
      wait_drained();
   endtask

   // result checker
   always @(posedge clock) begin
      ntt_out_type exp_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            errors++;
         end else begin
            exp_word = expected_q.pop_front();
            if (rsp_tdata[50:0] !== exp_word.residue) begin
               $error("residue: expected %0d actual %0d", exp_word.residue,
                      rsp_tdata[50:0]);
               errors++;
            end
            if (rsp_tdata[56:51] !== exp_word.position) begin
               $error("position: expected %0d actual %0d", exp_word.position,
                      rsp_tdata[56:51]);
               errors++;
            end
            if (rsp_tlast !== exp_word.last) begin
               $error("last: expected %0d actual %0d", exp_word.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("radix4_dif_ntt_64_unit regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(P_LARGE, 64'd1234567890123, 68, 0);
      test_random(64'd65537, 64'd65281, 0, 68);
      test_random(64'h7_FFFF_FFFF_FFFF, 64'h7_FFFF_FFFF_FFFE, 22, 22);
      if (errors == 0 && expected_q.size() == 0)
         $display("radix4_dif_ntt_64_unit regression: pass");
      else
         $display("radix4_dif_ntt_64_unit regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
